/* hdl/deq_pkg.sv */
`timescale 1ns / 1ps

package deq_pkg;

   // Field widths of one transaction, fixed by the interface.
   localparam int OP_W    = 3;
   localparam int WORD_W  = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   // Operation codes. Unused codes behave as a query.
   localparam logic [OP_W-1:0] OP_QUERY      = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;

   // Status codes.
   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic signed [WORD_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] popped_value;
      logic [STAT_W-1:0]        status;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] back_value;
      logic [COUNT_W-1:0]       item_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic fetch;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fetch_needed;
   } dp_stat_type;

endpackage

/* hdl/double_ended_queue_top.sv */
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit words with room for DEPTH entries.
// A transaction is accepted at a rising clock edge where start is high and
// busy is low; req_payload carries the operation (query, push back, push
// front, pop front, pop back) and the word to push.
// Each transaction produces exactly one response on rsp_payload, marked by
// rsp_valid for one clock cycle: the popped word, a status (ok, full on push,
// empty on pop), the front and back words after the operation (zero when the
// queue is empty) and the item count. The receiver must take it in that cycle.
// The accepting edge starts execution, which is followed by the response, or
// for a pop that leaves at least one word, first by a refill read of the new
// end word from the storage memory (its read port is registered). busy stays
// high until the response cycle ends, so no new transaction is accepted
// before the response of the last one.
// The front and back words are held in registers, so only a pop reads memory.
// Synchronous reset empties the queue at once; the storage memory itself is
// not cleared because no entry is read before it has been written.
// The count output is five bits wide and reports the occupancy modulo 32.

module double_ended_queue_top
   import deq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   localparam int AW = $clog2(DEPTH);

   cmd_type           cmd;
   dp_stat_type       stat;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   // Sequencing: accept, execute, optional refill read, respond.
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Ring pointers, occupancy, end-word registers and the response fields.
   deq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_in      (req_payload),
      .rsp_out     (rsp_payload),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // Word storage for the ring.
   deq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The response strobe lasts exactly one cycle.
   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   // A response is only given while a transaction is outstanding.
   a_resp_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response while idle");

   // Accepting a transaction makes the block busy.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a transaction");

endmodule

/* hdl/deq_ram.sv */
`timescale 1ns / 1ps

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/deq_ctrl.sv */
`timescale 1ns / 1ps

module deq_ctrl
   import deq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dp_stat_type stat,
   output cmd_type     cmd,
   output logic        busy,
   output logic        rsp_valid
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.fetch_needed ? ST_FETCH : ST_RESP;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // An accepted transaction always proceeds to execution.
   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> cmd.exec)
      else $error("accepted transaction did not execute");

   // Execution without a refill read answers in the next cycle.
   a_exec_resp : assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && !stat.fetch_needed) |=> rsp_valid)
      else $error("response missing after execution");

   // After the response the block is ready for new work.
   a_resp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("block did not return to idle after response");

endmodule

/* hdl/deq_dpath.sv */
`timescale 1ns / 1ps

module deq_dpath
   import deq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output dp_stat_type              stat,
   input  req_type                  req_in,
   output rsp_type                  rsp_out,
   output logic                     ram_wr_en,
   output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
   output logic [WORD_W-1:0]        ram_wr_data,
   output logic                     ram_rd_en,
   output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
   input  logic [WORD_W-1:0]        ram_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   req_type             req_ff, req_in_d;
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [WORD_W-1:0]   front_ff, front_in;
   logic [WORD_W-1:0]   back_ff, back_in;
   logic [WORD_W-1:0]   popped_ff, popped_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic                refill_front_ff, refill_front_in;

   logic                is_full, is_empty, is_last;
   logic [AW-1:0]       pos_back_slot, pos_head_dec, pos_head_inc, pos_new_back;

   // Head plus offset stays below twice the depth, so one subtract wraps it.
   function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] sum);
      if (sum >= SW'(DEPTH)) begin
         return AW'(sum - SW'(DEPTH));
      end
      return AW'(sum);
   endfunction

   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign is_last  = (count_ff == CW'(1));

   assign pos_back_slot = ring_wrap(SW'(head_ff) + SW'(count_ff));
   assign pos_new_back  = ring_wrap(SW'(head_ff) + SW'(count_ff) - SW'(2));
   assign pos_head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign pos_head_inc  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);

   always_comb begin
      req_in_d          = req_ff;
      head_in           = head_ff;
      count_in          = count_ff;
      front_in          = front_ff;
      back_in           = back_ff;
      popped_in         = popped_ff;
      status_in         = status_ff;
      refill_front_in   = refill_front_ff;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = pos_back_slot;
      ram_wr_data       = req_ff.data_in;
      ram_rd_en         = 1'b0;
      ram_rd_addr       = pos_head_inc;
      stat.fetch_needed = 1'b0;

      if (cmd.load) begin
         req_in_d = req_in;
      end

      if (cmd.exec) begin
         popped_in = '0;
         status_in = STATUS_OK;
         case (req_ff.operation)
            OP_PUSH_BACK: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = pos_back_slot;
                  count_in    = count_ff + CW'(1);
                  back_in     = req_ff.data_in;
                  if (is_empty) begin
                     front_in = req_ff.data_in;
                  end
               end
            end
            OP_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = pos_head_dec;
                  head_in     = pos_head_dec;
                  count_in    = count_ff + CW'(1);
                  front_in    = req_ff.data_in;
                  if (is_empty) begin
                     back_in = req_ff.data_in;
                  end
               end
            end
            OP_POP_FRONT: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  popped_in = front_ff;
                  head_in   = pos_head_inc;
                  count_in  = count_ff - CW'(1);
                  if (is_last) begin
                     front_in = '0;
                     back_in  = '0;
                  end else begin
                     ram_rd_en         = 1'b1;
                     ram_rd_addr       = pos_head_inc;
                     stat.fetch_needed = 1'b1;
                     refill_front_in   = 1'b1;
                  end
               end
            end
            OP_POP_BACK: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  popped_in = back_ff;
                  count_in  = count_ff - CW'(1);
                  if (is_last) begin
                     front_in = '0;
                     back_in  = '0;
                  end else begin
                     ram_rd_en         = 1'b1;
                     ram_rd_addr       = pos_new_back;
                     stat.fetch_needed = 1'b1;
                     refill_front_in   = 1'b0;
                  end
               end
            end
            default: begin
               // Queries and unused codes leave the queue as it is.
            end
         endcase
      end

      if (cmd.fetch) begin
         if (refill_front_ff) begin
            front_in = ram_rd_data;
         end else begin
            back_in = ram_rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         front_ff <= '0;
         back_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         front_ff <= front_in;
         back_ff  <= back_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff          <= req_in_d;
      popped_ff       <= popped_in;
      status_ff       <= status_in;
      refill_front_ff <= refill_front_in;
   end

   assign rsp_out.popped_value = popped_ff;
   assign rsp_out.status       = status_ff;
   assign rsp_out.front_value  = front_ff;
   assign rsp_out.back_value   = back_ff;
   assign rsp_out.item_count   = COUNT_W'(count_ff);

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("occupancy exceeds capacity");

   a_head_range : assert property (@(posedge clock) disable iff (reset)
      head_ff <= AW'(DEPTH - 1))
      else $error("head pointer out of range");

   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (is_empty && !cmd.exec && !cmd.fetch) |-> (front_ff == '0 && back_ff == '0))
      else $error("empty queue shows nonzero end words");

endmodule
